[design/vld_pkg.sv]
`timescale 1ns / 1ps
package vld_pkg;

   localparam int VARINT_MAX_BYTES = 4;
   localparam int VAL_W            = 28;
   localparam int SUM_W            = 36;
   localparam int VCNT_W           = $clog2(VARINT_MAX_BYTES + 1);
   localparam logic [VAL_W-1:0] VAL_MAX          = {VAL_W{1'b1}};
   localparam logic [VAL_W-1:0] MAX_PAYLOAD_RST  = 28'd65535;

   localparam logic [7:0] IND_PLAIN     = 8'h00;
   localparam logic [7:0] IND_ENCRYPTED = 8'h01;

   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_IND,
      PH_LEN,
      PH_TYPE,
      PH_PAY,
      PH_DEAD
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_ENCRYPTED = 3'd1,
      ERR_BAD_IND   = 3'd2,
      ERR_LEN_LONG  = 3'd3,
      ERR_TYPE_LONG = 3'd4,
      ERR_TOO_LARGE = 3'd5
   } err_type;

   typedef struct packed {
      kind_type         kind;
      logic [VAL_W-1:0] msg_code;
      logic [VAL_W-1:0] body_len;
      logic [7:0]       payload_byte;
      logic             last;
      err_type          error_code;
   } rec_type;

   localparam rec_type REC_ZERO = '{
      kind: KIND_HEADER, msg_code: '0, body_len: '0,
      payload_byte: '0, last: 1'b0, error_code: ERR_NONE
   };

endpackage

[design/vld_parser.sv]
`timescale 1ns / 1ps
module vld_parser
   import vld_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       data_byte,
   input  logic             csr_wr_en,
   input  logic [VAL_W-1:0] csr_wr_data,
   output logic             push,
   output rec_type          rec
);

   phase_type         phase_ff, phase_in;
   logic [VAL_W-1:0]  accum_ff, accum_in;
   logic [VCNT_W-1:0] vcnt_ff, vcnt_in;
   logic [VAL_W-1:0]  held_ff, held_in;
   logic [VAL_W-1:0]  left_ff, left_in;
   logic [VAL_W-1:0]  max_payload_ff;

   logic [SUM_W-1:0]  v_add;
   logic [SUM_W-1:0]  v_sum;
   logic [VAL_W-1:0]  v_sat;
   logic [VCNT_W-1:0] v_cnt_next;
   logic              v_too_long;
   logic              v_done;
   logic [VAL_W-1:0]  left_dec;
   logic              too_large;

   // varint byte accumulate, saturating at the field width
   always_comb begin
      v_add      = SUM_W'(data_byte[6:0]) << (7 * vcnt_ff);
      v_sum      = SUM_W'(accum_ff) + v_add;
      v_sat      = (v_sum > SUM_W'(VAL_MAX)) ? VAL_MAX : v_sum[VAL_W-1:0];
      v_cnt_next = vcnt_ff + VCNT_W'(1);
      v_too_long = data_byte[7] && (v_cnt_next >= VCNT_W'(VARINT_MAX_BYTES));
      v_done     = !data_byte[7];
      left_dec   = (left_ff == '0) ? '0 : left_ff - VAL_W'(1);
      too_large  = held_ff > max_payload_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_IND: phase_in = (data_byte == IND_PLAIN) ? PH_LEN : PH_DEAD;
            PH_LEN: begin
               if (v_too_long)  phase_in = PH_DEAD;
               else if (v_done) phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               if (v_too_long)             phase_in = PH_DEAD;
               else if (v_done && too_large) phase_in = PH_DEAD;
               else if (v_done)             phase_in = (held_ff == '0) ? PH_IND : PH_PAY;
            end
            PH_PAY:  phase_in = (left_dec == '0) ? PH_IND : PH_PAY;
            PH_DEAD: phase_in = PH_DEAD;
            default: phase_in = PH_DEAD;
         endcase
      end
   end

   always_comb begin
      push     = 1'b0;
      rec      = REC_ZERO;
      accum_in = accum_ff;
      vcnt_in  = vcnt_ff;
      held_in  = held_ff;
      left_in  = left_ff;
      case (phase_ff)
         PH_IND: begin
            accum_in = '0;
            vcnt_in  = '0;
            if (data_byte != IND_PLAIN) begin
               push           = 1'b1;
               rec.kind       = KIND_ERROR;
               rec.last       = 1'b1;
               rec.error_code = (data_byte == IND_ENCRYPTED) ? ERR_ENCRYPTED : ERR_BAD_IND;
            end
         end
         PH_LEN: begin
            accum_in = v_sat;
            vcnt_in  = v_cnt_next;
            if (v_too_long) begin
               push           = 1'b1;
               rec.kind       = KIND_ERROR;
               rec.last       = 1'b1;
               rec.error_code = ERR_LEN_LONG;
            end else if (v_done) begin
               held_in  = v_sat;
               accum_in = '0;
               vcnt_in  = '0;
            end
         end
         PH_TYPE: begin
            accum_in = v_sat;
            vcnt_in  = v_cnt_next;
            if (v_too_long) begin
               push           = 1'b1;
               rec.kind       = KIND_ERROR;
               rec.last       = 1'b1;
               rec.error_code = ERR_TYPE_LONG;
            end else if (v_done) begin
               push     = 1'b1;
               accum_in = '0;
               vcnt_in  = '0;
               if (too_large) begin
                  rec.kind       = KIND_ERROR;
                  rec.last       = 1'b1;
                  rec.error_code = ERR_TOO_LARGE;
               end else begin
                  rec.kind     = KIND_HEADER;
                  rec.msg_code = v_sat;
                  rec.body_len = held_ff;
                  rec.last     = (held_ff == '0);
                  left_in      = held_ff;
               end
            end
         end
         PH_PAY: begin
            push             = 1'b1;
            left_in          = left_dec;
            rec.kind         = KIND_PAYLOAD;
            rec.payload_byte = data_byte;
            rec.last         = (left_dec == '0);
         end
         PH_DEAD: push = 1'b0;
         default: push = 1'b0;
      endcase
      push = push && take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IND;
         accum_ff       <= '0;
         vcnt_ff        <= '0;
         held_ff        <= '0;
         left_ff        <= '0;
         max_payload_ff <= MAX_PAYLOAD_RST;
      end else begin
         phase_ff <= phase_in;
         if (take) begin
            accum_ff <= accum_in;
            vcnt_ff  <= vcnt_in;
            held_ff  <= held_in;
            left_ff  <= left_in;
         end
         if (csr_wr_en) begin
            max_payload_ff <= csr_wr_data;
         end
      end
   end

   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEAD) |-> !push)
      else $error("result produced after error");

   a_error_kills: assert property (@(posedge clock) disable iff (reset)
      (push && rec.kind == KIND_ERROR) |=> (phase_ff == PH_DEAD))
      else $error("error result without entering dead phase");

   a_vcnt_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN || phase_ff == PH_TYPE)
         |-> (vcnt_ff < VCNT_W'(VARINT_MAX_BYTES)))
      else $error("varint byte count out of range");

endmodule

[design/vld_queue.sv]
`timescale 1ns / 1ps
module vld_queue
   import vld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output rec_type head_rec
);

   rec_type           entry_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == QCNT_W'(Q_DEPTH));
      not_empty = (count_ff != '0);
      head_rec  = entry_ff[rd_ptr_ff];
      wr_ptr_in = (wr_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      rd_ptr_in = (rd_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop)  rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue underflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(Q_DEPTH))
      else $error("queue count out of range");

endmodule

[design/vld_emit.sv]
`timescale 1ns / 1ps
module vld_emit
   import vld_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rec_type          in_rec,
   output logic             in_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [VAL_W-1:0] rsp_msg_code,
   output logic [VAL_W-1:0] rsp_body_len,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last,
   output logic [2:0]       rsp_error_code
);

   logic    valid_ff;
   rec_type rec_ff;
   logic    load;

   always_comb begin
      in_ready = !valid_ff || rsp_ready;
      load     = in_valid && in_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= in_rec;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = rec_ff.kind;
   assign rsp_msg_code     = rec_ff.msg_code;
   assign rsp_body_len     = rec_ff.body_len;
   assign rsp_payload_byte = rec_ff.payload_byte;
   assign rsp_last         = rec_ff.last;
   assign rsp_error_code   = rec_ff.error_code;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rec_ff.kind == KIND_ERROR) |-> rec_ff.last)
      else $error("error result without last");

   a_code_kind: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rec_ff.kind != KIND_ERROR) |-> (rec_ff.error_code == ERR_NONE))
      else $error("error code on non-error result");

endmodule

[design/varint_length_prefixed_deframer.sv]
`timescale 1ns / 1ps
// Length-prefixed frame deframer.
// req_ channel: one raw stream byte per request on req_data_byte, valid/ready.
// rsp_ channel: one result per header, per payload byte and per error;
//   rsp_kind tells which, rsp_last closes a frame (or marks an error).
// csr_ port: csr_wr_en with csr_wr_data sets max_payload; write only while idle.
// Frame: 0x00 indicator, length varint, type varint (up to 4 bytes each),
//   then the payload bytes, passed out as they arrive.
// Throughput: one byte per cycle while the queue has room; indicator and
//   varint bytes other than the last type byte produce a result only on an error.
// Path: the parser writes a result into the 2-entry queue at the edge that
//   accepted its byte; the output register loads it from the queue once
//   that register is free, and from there it is shown on rsp_.
// Stall: rsp_ holds while rsp_ready is low; the queue absorbs two more
//   results, then req_ready drops until the receiver drains.
// Reset: parser back to waiting for an indicator, max_payload = 65535,
//   queue and output emptied. After any error every byte is accepted and
//   dropped until the next reset.
module varint_length_prefixed_deframer
   import vld_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [VAL_W-1:0] rsp_msg_code,
   output logic [VAL_W-1:0] rsp_body_len,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last,
   output logic [2:0]       rsp_error_code,
   input  logic             csr_wr_en,
   input  logic [VAL_W-1:0] csr_wr_data
);

   logic    take;
   logic    push;
   rec_type push_rec;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;
   rec_type q_head;
   logic    emit_ready;

   // accept whenever the queue has room, even when the request yields nothing
   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;
   assign q_pop     = q_not_empty && emit_ready;

   // front: classify each byte and form the result record
   vld_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (req_data_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .rec         (push_rec)
   );

   // decouple front from back so each can stall on its own
   vld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .head_rec  (q_head)
   );

   // back: hold the result on the rsp_ ports until taken
   vld_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (q_not_empty),
      .in_rec           (q_head),
      .in_ready         (emit_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_msg_code     (rsp_msg_code),
      .rsp_body_len     (rsp_body_len),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .rsp_error_code   (rsp_error_code)
   );

endmodule
